[src/aat_pkg.sv]
// aat_pkg: types, widths and register codes for the affine box transform
// no dependencies; used by every module of the block
package aat_pkg;

    localparam int FIELD_W        = 32;
    localparam int MAT_W          = 32;
    localparam int FRAC_W         = 16;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int NUM_AXES       = 3;
    localparam int NUM_REGS       = 6;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;
    localparam int NUM_STAGES     = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ROW0_COLS01 = 3'd0,
        REG_ROW0_COLS23 = 3'd1,
        REG_ROW1_COLS01 = 3'd2,
        REG_ROW1_COLS23 = 3'd3,
        REG_ROW2_COLS01 = 3'd4,
        REG_ROW2_COLS23 = 3'd5
    } reg_idx_t;

    localparam logic [CFG_DATA_W-1:0] CFG_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000,
        64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000,
        64'h0000_0000_0001_0000
    };

    typedef struct packed {
        logic signed [FIELD_W-1:0] lo_x;
        logic signed [FIELD_W-1:0] lo_y;
        logic signed [FIELD_W-1:0] lo_z;
        logic signed [FIELD_W-1:0] hi_x;
        logic signed [FIELD_W-1:0] hi_y;
        logic signed [FIELD_W-1:0] hi_z;
    } box_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] new_lo_x;
        logic signed [FIELD_W-1:0] new_lo_y;
        logic signed [FIELD_W-1:0] new_lo_z;
        logic signed [FIELD_W-1:0] new_hi_x;
        logic signed [FIELD_W-1:0] new_hi_y;
        logic signed [FIELD_W-1:0] new_hi_z;
        logic        [FIELD_W-1:0] side_x;
        logic        [FIELD_W-1:0] side_y;
        logic        [FIELD_W-1:0] side_z;
        logic                      overflow;
    } res_t;

    // one matrix row plus its translation
    typedef struct packed {
        logic signed [MAT_W-1:0] m0;
        logic signed [MAT_W-1:0] m1;
        logic signed [MAT_W-1:0] m2;
        logic signed [MAT_W-1:0] tr;
    } row_t;

    typedef struct packed {
        logic signed [FIELD_W-1:0] lo;
        logic signed [FIELD_W-1:0] hi;
        logic        [FIELD_W-1:0] side;
        logic                      ovf;
    } lane_res_t;

    // per-stage load enables from the pipeline control
    typedef struct packed {
        logic [NUM_STAGES-1:0] en;
    } stage_ctl_t;

endpackage

[src/aat_pipe_ctrl.sv]
// aat_pipe_ctrl: valid bits and per-stage load enables of the four-stage pipeline
// depends on aat_pkg
module aat_pipe_ctrl
    import aat_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       box_valid,
    output logic       box_stall,
    output logic       res_valid,
    input  logic       res_stall,
    output stage_ctl_t ctl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] ready;

    always_comb
    begin
        ready[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || !res_stall;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
        valid_next[0] = ready[0] ? box_valid : valid_reg[0];
        for (int k = 1; k < NUM_STAGES; k++)
        begin
            valid_next[k] = ready[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign ctl.en    = ready;
    assign box_stall = !ready[0];
    assign res_valid = valid_reg[NUM_STAGES-1];

endmodule

[src/aat_lane.sv]
// aat_lane: datapath of one output axis: products, min/max, sums, saturation
// depends on aat_pkg; enables come from aat_pipe_ctrl
module aat_lane
    import aat_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic       clk,
    input  stage_ctl_t ctl,
    input  box_t       box,
    input  row_t       row,
    output lane_res_t  lane_res
);

    localparam int PROD_W  = MAT_W + COORD_WIDTH;
    localparam int SHIFT_W = PROD_W - FRAC_W;
    localparam int SUM_W   = SHIFT_W + 2;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-COORD_WIDTH+1){1'b0}}, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO = ~SAT_HI;

    logic signed [COORD_WIDTH-1:0] c_lo [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] c_hi [NUM_AXES];
    logic signed [MAT_W-1:0]       m    [NUM_AXES];
    logic signed [PROD_W-1:0]      p_lo [NUM_AXES];
    logic signed [PROD_W-1:0]      p_hi [NUM_AXES];

    logic signed [SHIFT_W-1:0] a_reg  [NUM_AXES];
    logic signed [SHIFT_W-1:0] b_reg  [NUM_AXES];
    logic signed [SHIFT_W-1:0] mn_reg [NUM_AXES];
    logic signed [SHIFT_W-1:0] mx_reg [NUM_AXES];
    logic signed [SUM_W-1:0]   smin_reg;
    logic signed [SUM_W-1:0]   smax_reg;
    logic signed [SUM_W-1:0]   smin_next;
    logic signed [SUM_W-1:0]   smax_next;

    logic signed [COORD_WIDTH-1:0] lo_sat;
    logic signed [COORD_WIDTH-1:0] hi_sat;
    logic signed [FIELD_W-1:0]     lo_ext;
    logic signed [FIELD_W-1:0]     hi_ext;
    logic                          ovf_next;
    lane_res_t                     res_reg;

    always_comb
    begin
        c_lo[0] = box.lo_x[COORD_WIDTH-1:0];
        c_lo[1] = box.lo_y[COORD_WIDTH-1:0];
        c_lo[2] = box.lo_z[COORD_WIDTH-1:0];
        c_hi[0] = box.hi_x[COORD_WIDTH-1:0];
        c_hi[1] = box.hi_y[COORD_WIDTH-1:0];
        c_hi[2] = box.hi_z[COORD_WIDTH-1:0];
        m[0]    = row.m0;
        m[1]    = row.m1;
        m[2]    = row.m2;
        for (int j = 0; j < NUM_AXES; j++)
        begin
            p_lo[j] = m[j] * c_lo[j];
            p_hi[j] = m[j] * c_hi[j];
        end
    end

    // stage 0: products, floor shift by the fraction width
    always_ff @(posedge clk)
    begin
        if (ctl.en[0])
        begin
            for (int j = 0; j < NUM_AXES; j++)
            begin
                a_reg[j] <= p_lo[j][PROD_W-1:FRAC_W];
                b_reg[j] <= p_hi[j][PROD_W-1:FRAC_W];
            end
        end
    end

    // stage 1: order each pair
    always_ff @(posedge clk)
    begin
        if (ctl.en[1])
        begin
            for (int j = 0; j < NUM_AXES; j++)
            begin
                mn_reg[j] <= (a_reg[j] < b_reg[j]) ? a_reg[j] : b_reg[j];
                mx_reg[j] <= (a_reg[j] < b_reg[j]) ? b_reg[j] : a_reg[j];
            end
        end
    end

    // stage 2: exact sums with translation
    always_comb
    begin
        smin_next = SUM_W'(row.tr) + SUM_W'(mn_reg[0]) + SUM_W'(mn_reg[1])
                  + SUM_W'(mn_reg[2]);
        smax_next = SUM_W'(row.tr) + SUM_W'(mx_reg[0]) + SUM_W'(mx_reg[1])
                  + SUM_W'(mx_reg[2]);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[2])
        begin
            smin_reg <= smin_next;
            smax_reg <= smax_next;
        end
    end

    // stage 3: saturation, side and flag
    always_comb
    begin
        ovf_next = 1'b0;
        if (smin_reg > SAT_HI)
        begin
            lo_sat   = SAT_HI[COORD_WIDTH-1:0];
            ovf_next = 1'b1;
        end
        else if (smin_reg < SAT_LO)
        begin
            lo_sat   = SAT_LO[COORD_WIDTH-1:0];
            ovf_next = 1'b1;
        end
        else
        begin
            lo_sat = smin_reg[COORD_WIDTH-1:0];
        end
        if (smax_reg > SAT_HI)
        begin
            hi_sat   = SAT_HI[COORD_WIDTH-1:0];
            ovf_next = 1'b1;
        end
        else if (smax_reg < SAT_LO)
        begin
            hi_sat   = SAT_LO[COORD_WIDTH-1:0];
            ovf_next = 1'b1;
        end
        else
        begin
            hi_sat = smax_reg[COORD_WIDTH-1:0];
        end
        lo_ext = FIELD_W'(lo_sat);
        hi_ext = FIELD_W'(hi_sat);
    end

    always_ff @(posedge clk)
    begin
        if (ctl.en[3])
        begin
            res_reg.lo   <= lo_ext;
            res_reg.hi   <= hi_ext;
            res_reg.side <= hi_ext - lo_ext;
            res_reg.ovf  <= ovf_next;
        end
    end

    assign lane_res = res_reg;

endmodule

[src/aabb_affine_transform.sv]
// aabb_affine_transform: top level, configuration registers, control and three lanes
// depends on aat_pkg, aat_pipe_ctrl and aat_lane
//
//  channel | signals                                  | direction | handshake
//  box     | box_valid, box_stall, box (box_t)        | in        | valid & !stall
//  res     | res_valid, res_stall, res (res_t)        | out       | valid & !stall
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| in        | valid & ready
//
// one box per cycle while the output is not stalled; a result becomes valid once its box has passed every stage below
// stages: multiply, min/max, sum, saturate into the output register
// a stalled output holds; empty stages still fill, so bubbles are squeezed out
// reset clears the valid bits and loads the identity transform
module aabb_affine_transform
    import aat_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  box_valid,
    output logic                  box_stall,
    input  box_t                  box,
    output logic                  res_valid,
    input  logic                  res_stall,
    output res_t                  res,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [CFG_DATA_W-1:0] cfg_reg  [NUM_REGS];
    logic [CFG_DATA_W-1:0] cfg_next [NUM_REGS];
    row_t                  row      [NUM_AXES];
    lane_res_t             lane_res [NUM_AXES];
    stage_ctl_t            ctl;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        for (int i = 0; i < NUM_REGS; i++)
        begin
            cfg_next[i] = cfg_reg[i];
        end
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_ROW0_COLS01: cfg_next[REG_ROW0_COLS01] = cfg_data;
                REG_ROW0_COLS23: cfg_next[REG_ROW0_COLS23] = cfg_data;
                REG_ROW1_COLS01: cfg_next[REG_ROW1_COLS01] = cfg_data;
                REG_ROW1_COLS23: cfg_next[REG_ROW1_COLS23] = cfg_data;
                REG_ROW2_COLS01: cfg_next[REG_ROW2_COLS01] = cfg_data;
                REG_ROW2_COLS23: cfg_next[REG_ROW2_COLS23] = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= CFG_RESET[i];
            end
        end
        else
        begin
            for (int i = 0; i < NUM_REGS; i++)
            begin
                cfg_reg[i] <= cfg_next[i];
            end
        end
    end

    always_comb
    begin
        for (int r = 0; r < NUM_AXES; r++)
        begin
            row[r].m0 = cfg_reg[2*r][MAT_W-1:0];
            row[r].m1 = cfg_reg[2*r][2*MAT_W-1:MAT_W];
            row[r].m2 = cfg_reg[2*r+1][MAT_W-1:0];
            row[r].tr = cfg_reg[2*r+1][2*MAT_W-1:MAT_W];
        end
    end

    aat_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .box_valid (box_valid),
        .box_stall (box_stall),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .ctl       (ctl)
    );

    for (genvar r = 0; r < NUM_AXES; r++)
    begin : g_lane
        aat_lane #(
            .COORD_WIDTH (COORD_WIDTH)
        ) u_lane (
            .clk      (clk),
            .ctl      (ctl),
            .box      (box),
            .row      (row[r]),
            .lane_res (lane_res[r])
        );
    end

    always_comb
    begin
        res.new_lo_x = lane_res[0].lo;
        res.new_lo_y = lane_res[1].lo;
        res.new_lo_z = lane_res[2].lo;
        res.new_hi_x = lane_res[0].hi;
        res.new_hi_y = lane_res[1].hi;
        res.new_hi_z = lane_res[2].hi;
        res.side_x   = lane_res[0].side;
        res.side_y   = lane_res[1].side;
        res.side_z   = lane_res[2].side;
        res.overflow = lane_res[0].ovf | lane_res[1].ovf | lane_res[2].ovf;
    end

endmodule

[src/aat_checker.sv]
// aat_checker: port-level assertions for aabb_affine_transform, bound to the top
// depends on aat_pkg
module aat_checker
    import aat_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic box_valid,
    input logic box_stall,
    input logic res_valid,
    input logic res_stall,
    input res_t res
);

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(res))
        else $error("stalled result changed");

    // input stalls only while the output is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        box_stall |-> res_valid && res_stall)
        else $error("input stalled with output free");

    // an accepted box reaches the output when the output does not stall in between
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && !box_stall ##1 !res_stall ##1 !res_stall ##1 !res_stall
        |=> res_valid)
        else $error("result missing after four cycles");

    // result box is ordered in x and side_x matches
    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res.new_hi_x >= res.new_lo_x
                   && res.side_x == FIELD_W'(res.new_hi_x - res.new_lo_x))
        else $error("result box inverted or side wrong");

endmodule

bind aabb_affine_transform aat_checker u_chk (.*);

[verif/tb_top.sv]
`timescale 1ns / 100ps
// tb_top: self-checking testbench for aabb_affine_transform, with directed and random boxes
// depends on aat_pkg and the aabb_affine_transform rtl; predicts each result in place
module tb_top
    import aat_pkg::*;
();

    localparam int COORD_W      = COORD_WIDTH_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = NUM_STAGES + 4;
    localparam int IDLE_PCT     = 31;
    localparam int Q_ONE        = 32'h0001_0000;
    localparam int Q_HALF       = 32'h0000_8000;
    localparam int Q_MAX        = 32'h7fff_ffff;
    localparam int Q_MIN        = -2147483647 - 1;

    // indexes past the last register, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  box_valid = 1'b0;
    logic                  box_stall;
    box_t                  box = '0;
    logic                  res_valid;
    logic                  res_stall = 1'b0;
    res_t                  res;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [CFG_DATA_W-1:0] xform_regs [NUM_REGS];
    res_t                  expected_boxes [$];
    int                    mismatches = 0;
    int                    cycle_count = 0;
    bit                    calm = 1'b0;

    aabb_affine_transform dut (.*);

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
        res_stall <= calm ? 1'b0 : ($urandom_range(99) < IDLE_PCT);

    function automatic longint widen(input logic [31:0] v, input int w);
        longint t;
        t = longint'({32'b0, v});
        t = t <<< (64 - w);
        return t >>> (64 - w);
    endfunction

    function automatic longint clamp(input longint v, inout bit ovf);
        longint top;
        top = (longint'(1) <<< (COORD_W - 1)) - 1;
        if (v > top)
        begin
            ovf = 1'b1;
            return top;
        end
        if (v < -top - 1)
        begin
            ovf = 1'b1;
            return -top - 1;
        end
        return v;
    endfunction

    function automatic res_t transform_box(input box_t b);
        longint      lo_c [3];
        longint      hi_c [3];
        longint      m, a, p, smin, smax;
        logic [31:0] out_lo [3];
        logic [31:0] out_hi [3];
        logic [31:0] out_side [3];
        bit          ovf;
        res_t        r;
        lo_c[0] = widen(b.lo_x, COORD_W);
        lo_c[1] = widen(b.lo_y, COORD_W);
        lo_c[2] = widen(b.lo_z, COORD_W);
        hi_c[0] = widen(b.hi_x, COORD_W);
        hi_c[1] = widen(b.hi_y, COORD_W);
        hi_c[2] = widen(b.hi_z, COORD_W);
        ovf = 1'b0;
        for (int row = 0; row < NUM_AXES; row++)
        begin
            smin = widen(xform_regs[2*row + 1][63:32], MAT_W);
            smax = smin;
            for (int col = 0; col < NUM_AXES; col++)
            begin
                m = widen(col == 1 ? xform_regs[2*row][63:32]
                                   : xform_regs[2*row + col/2][31:0], MAT_W);
                a = (m * lo_c[col]) >>> FRAC_W;
                p = (m * hi_c[col]) >>> FRAC_W;
                smin += (a < p) ? a : p;
                smax += (a < p) ? p : a;
            end
            smin = clamp(smin, ovf);
            smax = clamp(smax, ovf);
            out_lo[row]   = smin[31:0];
            out_hi[row]   = smax[31:0];
            out_side[row] = 32'(smax - smin);
        end
        r.new_lo_x = out_lo[0];
        r.new_lo_y = out_lo[1];
        r.new_lo_z = out_lo[2];
        r.new_hi_x = out_hi[0];
        r.new_hi_y = out_hi[1];
        r.new_hi_z = out_hi[2];
        r.side_x   = out_side[0];
        r.side_y   = out_side[1];
        r.side_z   = out_side[2];
        r.overflow = ovf;
        return r;
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input res_t got);
        res_t want;
        if (expected_boxes.size() == 0)
        begin
            $error("result transfer with no box outstanding");
            mismatches++;
        end
        else
        begin
            want = expected_boxes.pop_front();
            check_field("new_lo_x", want.new_lo_x, got.new_lo_x);
            check_field("new_lo_y", want.new_lo_y, got.new_lo_y);
            check_field("new_lo_z", want.new_lo_z, got.new_lo_z);
            check_field("new_hi_x", want.new_hi_x, got.new_hi_x);
            check_field("new_hi_y", want.new_hi_y, got.new_hi_y);
            check_field("new_hi_z", want.new_hi_z, got.new_hi_z);
            check_field("side_x", want.side_x, got.side_x);
            check_field("side_y", want.side_y, got.side_y);
            check_field("side_z", want.side_z, got.side_z);
            check_field("overflow", 32'(want.overflow), 32'(got.overflow));
        end
    endtask

    always @(posedge clk)
        if (rst_n && res_valid && !res_stall)
            check_result(res);

    task automatic send_box(input box_t b);
        int gap;
        gap = 0;
        if (!calm)
            while ($urandom_range(99) < IDLE_PCT)
                gap++;
        if (gap > 0)
        begin
            box_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        box_valid <= 1'b1;
        box <= b;
        do @(posedge clk); while (box_stall);
        expected_boxes.push_back(transform_box(b));
    endtask

    task automatic settle();
        box_valid <= 1'b0;
        while (expected_boxes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // leaves cfg_valid high; the caller drops it after its last write
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        do @(posedge clk); while (!cfg_ready);
        if (idx < NUM_REGS)
            xform_regs[idx] = data;
    endtask

    task automatic load_transform(input int m [9], input int t [3]);
        settle();
        for (int row = 0; row < NUM_AXES; row++)
        begin
            cfg_write(reg_idx_t'(2*row), {m[3*row + 1], m[3*row]});
            cfg_write(reg_idx_t'(2*row + 1), {t[row], m[3*row + 2]});
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic box_t make_box(input int lx, input int ly, input int lz,
                                      input int hx, input int hy, input int hz);
        box_t b;
        b.lo_x = lx;
        b.lo_y = ly;
        b.lo_z = lz;
        b.hi_x = hx;
        b.hi_y = hy;
        b.hi_z = hz;
        return b;
    endfunction

    function automatic int rand_entry();
        case ($urandom_range(7))
            0: case ($urandom_range(4))
                0: return Q_MAX;
                1: return Q_MIN;
                2: return 0;
                3: return Q_ONE;
                default: return -Q_ONE;
            endcase
            1, 2: return int'($urandom());
            default: return int'($urandom_range(1 << 19)) - (1 << 18);
        endcase
    endfunction

    function automatic int rand_coord();
        case ($urandom_range(9))
            0: case ($urandom_range(4))
                0: return Q_MAX;
                1: return Q_MIN;
                2: return 0;
                3: return 1;
                default: return -1;
            endcase
            1, 2, 3: return int'($urandom());
            default: return int'($urandom_range(1 << 25)) - (1 << 24);
        endcase
    endfunction

    function automatic box_t rand_box();
        int lo [3];
        int hi [3];
        int tmp;
        bit tidy;
        tidy = $urandom_range(99) < 85;
        for (int ax = 0; ax < NUM_AXES; ax++)
        begin
            lo[ax] = rand_coord();
            hi[ax] = $urandom_range(9) == 0 ? lo[ax] : rand_coord();
            if (tidy && lo[ax] > hi[ax])
            begin
                tmp = lo[ax];
                lo[ax] = hi[ax];
                hi[ax] = tmp;
            end
        end
        return make_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2]);
    endfunction

    task automatic random_transform(input bit tame);
        int m [9];
        int t [3];
        for (int i = 0; i < 9; i++)
            m[i] = tame ? int'($urandom_range(1 << 19)) - (1 << 18) : rand_entry();
        for (int i = 0; i < 3; i++)
            t[i] = tame ? int'($urandom_range(1 << 25)) - (1 << 24) : rand_entry();
        load_transform(m, t);
    endtask

    task automatic test_identity_boxes();
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        send_box(make_box(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN));
        send_box(make_box(-Q_ONE, -2 * Q_ONE, -3, Q_ONE, 5, 7));
        send_box(make_box(1, -1, Q_MIN, -1, 1, Q_MIN));
    endtask

    task automatic test_floor_rounding();
        int m [9];
        int t [3];
        m = '{Q_HALF, 0, -Q_HALF, 0, -Q_HALF, 0, Q_HALF, 0, Q_HALF};
        t = '{-1, 0, 1};
        load_transform(m, t);
        send_box(make_box(-1, -1, -1, 1, 1, 1));
        send_box(make_box(-3, 3, -Q_ONE - 1, 3, -3, Q_ONE + 1));
    endtask

    task automatic test_saturation();
        int m [9];
        int t [3];
        m = '{default: Q_MAX};
        t = '{default: Q_MAX};
        load_transform(m, t);
        send_box(make_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        send_box(make_box(0, 0, 0, 0, 0, 0));
        send_box(make_box(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE));
        m = '{default: Q_MIN};
        t = '{default: Q_MIN};
        load_transform(m, t);
        send_box(make_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX));
        send_box(make_box(1, 1, 1, 1, 1, 1));
        send_box(make_box(0, 0, 0, 0, 0, 0));
    endtask

    task automatic test_zero_matrix();
        int m [9];
        int t [3];
        m = '{default: 0};
        t = '{Q_MAX, Q_MIN, 12345};
        load_transform(m, t);
        send_box(make_box(Q_MIN, Q_MAX, -1, Q_MAX, Q_MIN, 1));
        send_box(make_box(7, 7, 7, 9, 9, 9));
    endtask

    task automatic test_spare_index();
        settle();
        cfg_write(REG_SPARE_6, {$urandom(), $urandom()});
        cfg_write(REG_SPARE_7, {$urandom(), $urandom()});
        cfg_valid <= 1'b0;
        send_box(make_box(-Q_ONE, 2, Q_MIN, Q_ONE, 3, Q_MAX));
        send_box(make_box(Q_MAX, 0, -5, Q_MIN, 0, 5));
    endtask

    task automatic test_random_transforms();
        for (int phase = 0; phase < 8; phase++)
        begin
            random_transform(phase == 0);
            repeat (55) send_box(rand_box());
        end
    endtask

    task automatic test_full_rate();
        random_transform(1'b1);
        calm = 1'b1;
        repeat (100) send_box(rand_box());
        settle();
        calm = 1'b0;
    endtask

    initial
    begin
        xform_regs[REG_ROW0_COLS01] = 64'h0000_0000_0001_0000;
        xform_regs[REG_ROW0_COLS23] = 64'h0000_0000_0000_0000;
        xform_regs[REG_ROW1_COLS01] = 64'h0001_0000_0000_0000;
        xform_regs[REG_ROW1_COLS23] = 64'h0000_0000_0000_0000;
        xform_regs[REG_ROW2_COLS01] = 64'h0000_0000_0000_0000;
        xform_regs[REG_ROW2_COLS23] = 64'h0000_0000_0001_0000;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_identity_boxes();
        test_floor_rounding();
        test_saturation();
        test_zero_matrix();
        test_spare_index();
        test_random_transforms();
        test_full_rate();
        settle();
        if (mismatches == 0 && expected_boxes.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

[files.f]
src/aat_pkg.sv
src/aat_pipe_ctrl.sv
src/aat_lane.sv
src/aabb_affine_transform.sv
src/aat_checker.sv
verif/tb_top.sv
